[sv/dspm_pkg.sv]
// ----------------------------------------------------------------------------
// dspm_pkg
// Shared types and constants of the dot-star pattern matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package dspm_pkg;

	localparam int unsigned MAX_PATTERN_DEF = 16;
	localparam int unsigned PAT_CHARS       = 16;
	localparam int unsigned BYTE_W          = 8;
	localparam int unsigned LEN_W           = 5;
	localparam int unsigned CFG_W           = 64;
	localparam int unsigned CFG_IDX_W       = 2;

	localparam logic [BYTE_W-1:0] CH_DOT  = 8'h2E;
	localparam logic [BYTE_W-1:0] CH_STAR = 8'h2A;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CHARS_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHARS_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH     = 2'd2;

	typedef enum logic {
		ST_EMPTY,
		ST_BUSY
	} state_t;

	typedef struct packed {
		logic capture;
		logic step;
	} ctl_cmd_t;

	typedef struct packed {
		logic item_last;
	} dp_status_t;

endpackage

`default_nettype wire

[sv/dspm_in_if.sv]
// ----------------------------------------------------------------------------
// dspm_in_if
// Subject item channel: valid/ready handshake with one subject byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface dspm_in_if;
	logic                        valid;
	logic                        ready;
	logic [dspm_pkg::BYTE_W-1:0] subject_byte;
	logic                        byte_valid;
	logic                        end_of_subject;

	modport source (output valid, output subject_byte, output byte_valid,
		output end_of_subject, input ready);
	modport sink (input valid, input subject_byte, input byte_valid,
		input end_of_subject, output ready);
endinterface

`default_nettype wire

[sv/dspm_out_if.sv]
// ----------------------------------------------------------------------------
// dspm_out_if
// Result channel: valid/ready handshake with the match bit.
// ----------------------------------------------------------------------------
`default_nettype none

interface dspm_out_if;
	logic valid;
	logic ready;
	logic matched;

	modport source (output valid, output matched, input ready);
	modport sink (input valid, input matched, output ready);
endinterface

`default_nettype wire

[sv/dspm_ctrl.sv]
// ----------------------------------------------------------------------------
// dspm_ctrl
// Controller: tracks the pending item and the result register handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module dspm_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	input  wire dspm_pkg::dp_status_t   status,
	output dspm_pkg::ctl_cmd_t          cmd
);
	import dspm_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		unique case (state_q)
			ST_EMPTY: begin
				cmd.step = 1'b0;
			end
			ST_BUSY: begin
				// a last item waits until the result register is free
				cmd.step = !(status.item_last && out_valid_q && !out_ready);
			end
			default: begin
				cmd.step = 1'b0;
			end
		endcase
		in_ready    = (state_q == ST_EMPTY) || cmd.step;
		cmd.capture = in_valid && in_ready;
		if (cmd.capture) begin
			state_d = ST_BUSY;
		end else if (cmd.step) begin
			state_d = ST_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step && status.item_last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	a_accept_busy_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.capture && state_q == ST_BUSY) |-> cmd.step)
		else $error("item taken while pending item not stepped");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.step && status.item_last && out_valid_q && !out_ready))
		else $error("result register overwritten");

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && status.item_last) |=> out_valid_q)
		else $error("last item produced no result");
`endif

endmodule

`default_nettype wire

[sv/dspm_dpath.sv]
// ----------------------------------------------------------------------------
// dspm_dpath
// Datapath: configuration registers, item register, match row with one
// cell per pattern position, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dspm_dpath #(
	parameter int unsigned MAX_PATTERN = dspm_pkg::MAX_PATTERN_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [dspm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [dspm_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic [dspm_pkg::BYTE_W-1:0]    subject_byte,
	input  wire logic                           byte_valid,
	input  wire logic                           end_of_subject,
	input  wire dspm_pkg::ctl_cmd_t             cmd,
	output dspm_pkg::dp_status_t                status,
	output logic                                matched
);
	import dspm_pkg::*;

	localparam int unsigned NW = $clog2(MAX_PATTERN + 1);
	localparam int unsigned CW = (NW > LEN_W) ? NW : LEN_W;

	logic [CFG_W-1:0]  chars_low_q;
	logic [CFG_W-1:0]  chars_high_q;
	logic [LEN_W-1:0]  length_q;
	logic [BYTE_W-1:0] byte_s1;
	logic              byte_valid_s1;
	logic              last_s1;
	logic [MAX_PATTERN:0] row_q;
	logic              at_start_q;
	logic              matched_q;

	logic [2*CFG_W-1:0]   chars;
	logic [BYTE_W-1:0]    pchar [MAX_PATTERN];
	logic [CW-1:0]        len_ext;
	logic [NW-1:0]        n_used;
	logic [MAX_PATTERN:0] keep;
	logic [MAX_PATTERN:0] row0;
	logic [MAX_PATTERN:0] base;
	logic [MAX_PATTERN:0] adv;
	logic [MAX_PATTERN:0] nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_low_q  <= '0;
			chars_high_q <= '0;
			length_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CHARS_LOW:  chars_low_q  <= cfg_data;
				REG_CHARS_HIGH: chars_high_q <= cfg_data;
				REG_LENGTH:     length_q     <= cfg_data[LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign chars = {chars_high_q, chars_low_q};

	// characters past the configured window read as zero
	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_char
		if (k < PAT_CHARS) begin : g_in
			assign pchar[k] = chars[BYTE_W*k +: BYTE_W];
		end else begin : g_out
			assign pchar[k] = '0;
		end
	end

	// saturate the length to the row size
	always_comb begin
		len_ext = CW'(length_q);
		if (len_ext > CW'(MAX_PATTERN)) begin
			n_used = NW'(MAX_PATTERN);
		end else begin
			n_used = NW'(len_ext);
		end
	end

	for (genvar j = 0; j <= MAX_PATTERN; j++) begin : g_keep
		assign keep[j] = (NW'(j) <= n_used);
	end

	assign row0[0] = 1'b1;
	assign adv[0]  = 1'b0;
	assign base    = at_start_q ? (row0 & keep) : row_q;

	// one cell per column; star columns ripple from two columns back
	for (genvar j = 1; j <= MAX_PATTERN; j++) begin : g_col
		logic is_star;
		logic hit_cur;
		assign is_star = (pchar[j-1] == CH_STAR);
		assign hit_cur = (pchar[j-1] == CH_DOT) || (pchar[j-1] == byte_s1);
		if (j >= 2) begin : g_pair
			logic hit_prev;
			assign hit_prev = (pchar[j-2] == CH_DOT) || (pchar[j-2] == byte_s1);
			assign adv[j]  = is_star ? (adv[j-2] | (hit_prev & base[j]))
				: (hit_cur & base[j-1]);
			assign row0[j] = is_star & row0[j-2];
		end else begin : g_first
			// leading star has no column to repeat
			assign adv[j]  = !is_star && hit_cur && base[j-1];
			assign row0[j] = 1'b0;
		end
	end

	assign nxt = byte_valid_s1 ? (adv & keep) : base;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			byte_s1       <= subject_byte;
			byte_valid_s1 <= byte_valid;
			last_s1       <= end_of_subject;
		end
		if (cmd.step && last_s1) begin
			matched_q <= nxt[n_used];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= '0;
			at_start_q <= 1'b1;
		end else if (cmd.step) begin
			row_q      <= nxt;
			at_start_q <= last_s1;
		end
	end

	assign status.item_last = last_s1;
	assign matched          = matched_q;

endmodule

`default_nettype wire

[sv/dot_star_pattern_matcher.sv]
// ----------------------------------------------------------------------------
// dot_star_pattern_matcher
// Whole-string match of streamed subject bytes against a configured pattern
// with '.' and 'X*'.
// Result: a last item's result enters the result register when the item
// steps out of the item register. Throughput: one item per cycle, set by the
// row update of the cells; a last item holds while the old result is untaken.
// Reset: pattern registers cleared, match row cleared, string start set;
// no clearing pass, items are taken right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module dot_star_pattern_matcher #(
	parameter int unsigned MAX_PATTERN = dspm_pkg::MAX_PATTERN_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [dspm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [dspm_pkg::CFG_W-1:0]     cfg_data,
	dspm_in_if.sink                             in_ch,
	dspm_out_if.source                          out_ch
);
	import dspm_pkg::*;

	ctl_cmd_t   cmd;
	dp_status_t status;

	dspm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	dspm_dpath #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.subject_byte   (in_ch.subject_byte),
		.byte_valid     (in_ch.byte_valid),
		.end_of_subject (in_ch.end_of_subject),
		.cmd            (cmd),
		.status         (status),
		.matched        (out_ch.matched)
	);

endmodule

`default_nettype wire
